[rtl/bffa_pkg.sv]
// ---------------------------------------------------------------------------
// Bitmap allocator package
// Field widths, default sizes and command codes shared by the allocator and
// its port checker.
// ---------------------------------------------------------------------------
package bffa_pkg;

	// Widths of the item fields and of the configuration register.
	localparam int COMMAND_W = 2;
	localparam int INDEX_W   = 14;
	localparam int COUNT_W   = 15;
	localparam int ACTIVE_W  = 15;

	// Default map geometry.
	localparam int MAP_BITS_DEF  = 16384;
	localparam int WORD_BITS_DEF = 32;

	// Value of the active size register after reset.
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 15'd16384;

	typedef enum logic [COMMAND_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_MARK  = 2'd2,
		CMD_COUNT = 2'd3
	} cmd_t;

endpackage

[rtl/bitmap_first_free_allocator.sv]
// ---------------------------------------------------------------------------
// Bitmap first-fit allocator
// Keeps one flag per unit in an on-chip word memory and serves allocate,
// free, mark and count commands, returning one result item per command.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Item contents
// in        sink       in_valid / in_stall     command, bit_index
// out       source     out_valid / out_stall   status, granted_index, used_count
// cfg       sink       cfg_valid / cfg_ready   active_bits
//
// Allocate scans the map one word per cycle, from word zero up to the
// first word with a free unit, or over all limit_words words when the map
// is full. Free and mark read the word, modify and write it back, then
// push the result; count goes straight to the result. The word scan over
// the single memory read port sets the allocate time.
// After reset a clearing pass writes every map word to zero, one word per
// cycle, with in_stall high; configuration writes are taken throughout.
// One command is worked on at a time. A finished result sits in the output
// register, so the next command is accepted while out_stall holds it; that
// command then waits in its last cycle until the output register is free.
//
module bitmap_first_free_allocator
	import bffa_pkg::*;
#(
	parameter int MAP_BITS  = MAP_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COMMAND_W-1:0] command,
	input  logic [INDEX_W-1:0]   bit_index,
	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 status,
	output logic [INDEX_W-1:0]   granted_index,
	output logic [COUNT_W-1:0]   used_count,
	// active size register
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ACTIVE_W-1:0]  active_bits
);

	// Map geometry. WORD_BITS is a power of two.
	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WB_LOG    = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(MAP_BITS + 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_MOD   = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration.
	logic [ACTIVE_W-1:0] active_q;

	// Map memory with a registered read port.
	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_en;
	logic [WA_W-1:0]      rd_addr;
	logic                 wr_en;
	logic [WA_W-1:0]      wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// Clearing pass.
	logic [WA_W-1:0] clr_addr_q;

	// Command held while it is worked on.
	cmd_t              cmd_q;
	logic [WA_W-1:0]   word_q;
	logic [WB_LOG-1:0] off_q;
	logic              in_range_q;

	// Allocation scan: limit, issue pointer and the word being checked.
	logic [CNT_W-1:0]  limit_q;
	logic [WA_W:0]     limit_words_q;
	logic [WA_W:0]     ptr_q;
	logic [WA_W-1:0]   chk_addr_s1;

	// Running count of used units and the pending result.
	logic [CNT_W-1:0]   cnt_q;
	logic               res_status_q;
	logic [INDEX_W-1:0] res_granted_q;

	// Output register.
	logic               out_valid_q;
	logic               status_q;
	logic [INDEX_W-1:0] granted_q;
	logic [COUNT_W-1:0] used_q;

	// Decode of the incoming item.
	logic              in_acc;
	cmd_t              in_cmd;
	logic [31:0]       idx_ext;
	logic              idx_in_range;
	logic [WA_W-1:0]   idx_word;
	logic [WB_LOG-1:0] idx_off;
	logic [CNT_W-1:0]  new_limit;
	logic [WA_W:0]     new_limit_words;

	assign in_acc    = in_valid && !in_stall && (state_q == ST_IDLE);
	assign in_cmd    = cmd_t'(command);
	assign idx_ext   = 32'(bit_index);
	assign idx_in_range = idx_ext < 32'(MAP_BITS);
	assign idx_word  = idx_ext[WB_LOG +: WA_W];
	assign idx_off   = idx_ext[WB_LOG-1:0];

	// Allocation never searches beyond the map itself.
	assign new_limit = (32'(active_q) > 32'(MAP_BITS)) ? CNT_W'(MAP_BITS)
	                                                   : CNT_W'(active_q);
	assign new_limit_words = (WA_W+1)'((32'(new_limit) + 32'(WORD_BITS - 1)) >> WB_LOG);

	// Scan check on the word that has just been read. Units at or above the
	// limit in the last, partly active word count as used.
	logic [WA_W:0]        last_word;
	logic                 is_last;
	logic [WB_LOG-1:0]    rem;
	logic [WORD_BITS-1:0] free_vec;
	logic                 found;
	logic [WB_LOG-1:0]    first_off;
	logic [31:0]          grant_ext;

	assign last_word = limit_words_q - (WA_W+1)'(1);
	assign is_last   = ((WA_W+1)'(chk_addr_s1) == last_word);
	assign rem       = limit_q[WB_LOG-1:0];

	always_comb begin
		for (int k = 0; k < WORD_BITS; k++) begin
			free_vec[k] = !rd_data_q[WORD_BITS-1-k] &&
			              !(is_last && (rem != '0) && (WB_LOG'(k) >= rem));
		end
	end

	// Lowest free offset; the bit order in a word is most significant first.
	always_comb begin
		first_off = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (free_vec[k]) begin
				first_off = WB_LOG'(k);
			end
		end
	end

	assign found     = |free_vec;
	assign grant_ext = 32'({chk_addr_s1, first_off});

	// Bit of the addressed unit in the word read for a free or mark.
	logic                 cur_bit;
	logic [WORD_BITS-1:0] one_hot_mod;
	logic [WORD_BITS-1:0] one_hot_alloc;
	logic                 mod_clear;
	logic                 mod_set;

	assign one_hot_mod   = {{(WORD_BITS-1){1'b0}}, 1'b1} << (~off_q);
	assign one_hot_alloc = {{(WORD_BITS-1){1'b0}}, 1'b1} << (~first_off);
	assign cur_bit       = |(rd_data_q & one_hot_mod);
	assign mod_clear     = in_range_q && (cmd_q == CMD_FREE) && cur_bit;
	assign mod_set       = in_range_q && (cmd_q == CMD_MARK) && !cur_bit;

	// Memory read port.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (in_acc) begin
			rd_en   = (in_cmd == CMD_ALLOC) || idx_in_range;
			rd_addr = (in_cmd == CMD_ALLOC) ? '0 : idx_word;
		end else if (state_q == ST_SCAN) begin
			rd_en   = ptr_q < limit_words_q;
			rd_addr = ptr_q[WA_W-1:0];
		end
	end

	// Memory write port: clearing pass, allocation, or free and mark.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		priority case (1'b1)
			(state_q == ST_CLEAR): begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
			end
			(state_q == ST_SCAN): begin
				wr_en   = found;
				wr_addr = chk_addr_s1;
				wr_data = rd_data_q | one_hot_alloc;
			end
			(state_q == ST_MOD): begin
				wr_en   = mod_clear || mod_set;
				wr_addr = word_q;
				wr_data = mod_clear ? (rd_data_q & ~one_hot_mod) : (rd_data_q | one_hot_mod);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Configuration register; the port is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= active_bits;
		end
	end

	// The output register can take a new result this cycle.
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			cnt_q      <= '0;
			ptr_q      <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + WA_W'(1);
					if ((WA_W+1)'(clr_addr_q) == (WA_W+1)'(MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_cmd)
							CMD_ALLOC: begin
								if (new_limit == '0) begin
									state_q <= ST_PUSH;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							CMD_FREE, CMD_MARK: begin
								state_q <= ST_MOD;
							end
							CMD_COUNT: begin
								state_q <= ST_PUSH;
							end
						endcase
						ptr_q <= (WA_W+1)'(1);
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + (WA_W+1)'(1);
					if (found) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_PUSH;
					end else if (is_last) begin
						state_q <= ST_PUSH;
					end
				end
				ST_MOD: begin
					if (mod_clear) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (mod_set) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command and scan payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q         <= in_cmd;
			word_q        <= idx_word;
			off_q         <= idx_off;
			in_range_q    <= idx_in_range;
			limit_q       <= new_limit;
			limit_words_q <= new_limit_words;
			chk_addr_s1   <= '0;
			res_granted_q <= '0;
			res_status_q  <= (in_cmd == CMD_ALLOC) && (new_limit == '0);
		end else if (state_q == ST_SCAN) begin
			chk_addr_s1 <= ptr_q[WA_W-1:0];
			if (found) begin
				res_granted_q <= grant_ext[INDEX_W-1:0];
			end else if (is_last) begin
				res_status_q <= 1'b1;
			end
		end
	end

	// Output register.
	logic [31:0] cnt_ext;
	assign cnt_ext = 32'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_PUSH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH) && out_free) begin
			status_q  <= res_status_q;
			granted_q <= res_granted_q;
			used_q    <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign used_count    = used_q;

endmodule

[rtl/bffa_checker.sv]
// ---------------------------------------------------------------------------
// Bitmap allocator port checker
// Watches the ports of the allocator and checks item ordering, result
// consistency and the behaviour of the used count between results.
// ---------------------------------------------------------------------------
module bffa_checker
	import bffa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 status,
	input logic [INDEX_W-1:0]   granted_index,
	input logic [COUNT_W-1:0]   used_count
);

	logic               in_acc;
	logic               out_acc;
	logic [1:0]         pending_q;
	logic [COUNT_W-1:0] last_count_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Items accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_count_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc) begin
				last_count_q <= used_count;
			end
		end
	end

	// A stalled result holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(granted_index) && $stable(used_count))
		else $error("result item changed while stalled");

	// A full map never reports a granted unit.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> granted_index == '0)
		else $error("full status with a non-zero index");

	// Every result belongs to an accepted item, and at most two are in flight.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 2'd0)
		else $error("result item without an accepted command");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many items in flight");

	// One command moves the used count by at most one unit.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (used_count == last_count_q) ||
		(used_count == last_count_q + COUNT_W'(1)) ||
		(used_count == last_count_q - COUNT_W'(1)))
		else $error("used count jumped by more than one");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (.*);
